### hdl/kcc_pkg.sv
// Shared types and constants for the key click classifier.
package kcc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ACTIVE_LEVEL  = 3'd0,
    CFG_SHORT_TICKS   = 3'd1,
    CFG_LONG_TICKS    = 3'd2,
    CFG_REPEAT_TICKS  = 3'd3,
    CFG_DOUBLE_WINDOW = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned ByteWidth   = 8;

  typedef logic [ByteWidth-1:0] byte_t;

  // Status and event bit masks.
  localparam byte_t EV_PRESSED      = 8'h01;
  localparam byte_t EV_SHORT        = 8'h02;
  localparam byte_t EV_LONG         = 8'h04;
  localparam byte_t EV_LONG_ONCE    = 8'h44;
  localparam byte_t EV_LONG_RELEASE = 8'h0C;
  localparam byte_t EV_PENDING      = 8'h10;
  localparam byte_t EV_DOUBLE       = 8'h20;

  // Status bits carried over from one tick to the next.
  localparam byte_t KEEP_DOUBLE_ON  = 8'h3E;
  localparam byte_t KEEP_DOUBLE_OFF = 8'h0E;
  localparam byte_t MASK_DOUBLE_ON  = 8'hBE;
  localparam byte_t MASK_DOUBLE_OFF = 8'h8E;

  // Reset values of the configuration registers.
  localparam byte_t RST_ACTIVE_LEVEL  = 8'd0;
  localparam byte_t RST_SHORT_TICKS   = 8'd2;
  localparam byte_t RST_LONG_TICKS    = 8'd100;
  localparam byte_t RST_REPEAT_TICKS  = 8'd0;
  localparam byte_t RST_DOUBLE_WINDOW = 8'd0;

endpackage

### hdl/key_click_classifier.sv
// Key click classifier: short, long, repeat and double click detection per tick.
//
// Usage: every input transaction on the s_axis channel is one tick carrying
// the sampled key level and a mask of status bits to clear. Every tick
// produces exactly one output transaction on m_axis with the updated status
// byte and the events raised in that tick.
// Pipeline: an accepted tick is held in an input register, then classified
// by a single pass of compare and counter logic into the result register,
// from which its result is offered on m_axis.
// Throughput: one tick per cycle while the receiver is ready; the hold counter,
// window counter and status byte are updated in the same cycle as the
// classification, so consecutive ticks flow back to back.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; s_axis_tready drops once both are full.
// Configuration: cfg channel writes one 8-bit register per transaction and is
// always ready; write only while no tick is in flight.
// Reset clears counters, status and pipeline valids and restores register
// defaults (pressed level 0, short 2, long 100, no repeat, no double click).
module key_click_classifier #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Tick input; tdata: [7:0] key_level, [15:8] clear_flags.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,
  // Result output; tdata: [7:0] status, [15:8] new_events.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kcc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  kcc_pkg::byte_t                 cfg_data_i
);

  import kcc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  // Configuration registers.
  byte_t active_q, short_q, long_q, repeat_q, window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= RST_ACTIVE_LEVEL;
      short_q  <= RST_SHORT_TICKS;
      long_q   <= RST_LONG_TICKS;
      repeat_q <= RST_REPEAT_TICKS;
      window_q <= RST_DOUBLE_WINDOW;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE_LEVEL:  active_q <= cfg_data_i;
        CFG_SHORT_TICKS:   short_q  <= cfg_data_i;
        CFG_LONG_TICKS:    long_q   <= cfg_data_i;
        CFG_REPEAT_TICKS:  repeat_q <= cfg_data_i;
        CFG_DOUBLE_WINDOW: window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the input register advances whenever the result
  // register is empty or being drained.
  logic  in_valid_q;
  byte_t level_q, clear_q;
  logic  out_valid_q;
  logic  out_free;
  logic  advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      level_q <= s_axis_tdata[7:0];
      clear_q <= s_axis_tdata[15:8];
    end
  end

  // Classifier state.
  logic [COUNT_WIDTH-1:0] hold_q, hold_d;
  logic [COUNT_WIDTH-1:0] win_q, win_d;
  byte_t                  status_q, status_d;
  byte_t                  events_d;

  // Classification of one tick.
  logic                   pressed;
  byte_t                  st_clr;
  byte_t                  st_mid;
  byte_t                  ev;
  logic [COUNT_WIDTH-1:0] hold_inc, win_inc;
  logic [COUNT_WIDTH-1:0] lt_ext, ltr_ext;
  logic [8:0]             ltr_sum;

  always_comb begin
    pressed  = (level_q == active_q);
    st_clr   = status_q & ~clear_q;
    ev       = '0;
    hold_inc = (hold_q == CntMax) ? hold_q : hold_q + COUNT_WIDTH'(1);
    hold_d   = hold_inc;
    lt_ext   = COUNT_WIDTH'(long_q);
    ltr_sum  = {1'b0, long_q} + {1'b0, repeat_q};
    ltr_ext  = COUNT_WIDTH'(ltr_sum);

    // Hold time classification.
    if (hold_inc >= lt_ext) begin
      if ((repeat_q != '0) && (hold_inc > ltr_ext)) begin
        hold_d = lt_ext + COUNT_WIDTH'(1);
        ev     = ev | EV_LONG;
      end else if (hold_inc == lt_ext) begin
        ev = ev | EV_LONG_ONCE;
      end
      if (!pressed) begin
        ev     = ev | EV_LONG_RELEASE;
        hold_d = '0;
      end
    end else if (hold_inc > COUNT_WIDTH'(short_q)) begin
      if (!pressed) begin
        ev     = ev | EV_SHORT;
        hold_d = '0;
      end
    end else if (!pressed) begin
      hold_d = '0;
    end
    if (pressed) begin
      ev = ev | EV_PRESSED;
    end

    // Double click window and status carry-over.
    st_mid  = st_clr;
    win_inc = (win_q == CntMax) ? win_q : win_q + COUNT_WIDTH'(1);
    win_d   = win_q;
    if (window_q != '0) begin
      if ((ev & EV_SHORT) != '0) begin
        ev = (ev & ~EV_SHORT) | EV_PENDING;
      end
      if ((st_clr & EV_PENDING) != '0) begin
        win_d = win_inc;
        if (win_inc > COUNT_WIDTH'(window_q)) begin
          if ((ev & EV_PENDING) != '0) begin
            ev = (ev & ~EV_PENDING) | EV_DOUBLE;
          end else begin
            ev = ev | EV_SHORT;
          end
          win_d  = '0;
          st_mid = st_mid & ~EV_PENDING;
        end else if ((ev & EV_PENDING) != '0) begin
          ev     = (ev & ~EV_PENDING) | EV_DOUBLE;
          st_mid = st_mid & ~EV_PENDING;
          win_d  = '0;
        end
      end
      status_d = (({st_mid[0], 7'b0} | (st_mid & KEEP_DOUBLE_ON)) & MASK_DOUBLE_ON) | ev;
    end else begin
      status_d = (({st_mid[0], 7'b0} | (st_mid & KEEP_DOUBLE_OFF)) & MASK_DOUBLE_OFF) | ev;
    end
    events_d = ev;
  end

  // State update and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      win_q       <= '0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        hold_q   <= hold_d;
        win_q    <= win_d;
        status_q <= status_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= {events_d, status_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;

`ifndef ASSERT_OFF
  // A tick leaving the input register always lands in the result register.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("classified tick did not reach the result register");

  // Events of a tick are always merged into its status.
  a_events_in_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[7:0] & m_axis_tdata[15:8]) == m_axis_tdata[15:8]))
    else $error("event not reflected in status");

  // The previous-pressed bit is never raised as a new event.
  a_no_prev_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[15])
    else $error("previous-pressed bit raised as event");

  // Status tracks the result being offered while no tick waits in the input register.
  a_status_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !in_valid_q |-> (m_axis_tdata[7:0] == status_q))
    else $error("offered status differs from stored status");
`endif

endmodule
